/* rtl/sitrd_pkg.sv */
// Shared types and constants for the signed integer to radix digits block.
package sitrd_pkg;

  // Alphabet geometry and sign symbols
  localparam int unsigned SYM_COUNT     = 16;
  localparam int unsigned DIGIT_BITS    = 4;
  localparam int unsigned RADIX_BITS    = 5;
  localparam int unsigned DIV_STEP_BITS = 8;
  localparam logic [7:0]  SYM_PLUS      = 8'd43;
  localparam logic [7:0]  SYM_MINUS     = 8'd45;

  // Configuration register indexes (byte address is 8 times the index)
  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd1;
  localparam logic [1:0] REG_RADIX_COUNT  = 2'd2;

  typedef logic [SYM_COUNT-1:0][7:0] sym_table_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_SHOW
  } st_e;

  // Sequencer to divide unit
  typedef struct packed {
    logic start;
    logic run;
  } div_ctrl_t;

  // Divide unit to sequencer
  typedef struct packed {
    logic                  done;
    logic                  quot_zero;
    logic [DIGIT_BITS-1:0] digit;
  } div_stat_t;

endpackage

/* rtl/signed_integer_to_radix_digits_top.sv */
// Top level: signed integer to text in a configurable radix.
//
// Input channel: in_valid_i / in_stall_o with value_i, a two's complement
// number of VALUE_BITS bits. Output channel: out_valid_o / out_stall_i with
// character_o and last_o; one beat per emitted byte, last_o marks the final
// byte of a value. Configuration through the APB port: symbols_low at 0x00,
// symbols_high at 0x08, radix_count at 0x10; write only while idle.
// One value is handled at a time; in_stall_o is high from acceptance until
// the last beat of that value is taken. If the alphabet is not a valid base
// the value is dropped and the block is ready again on the next cycle.
// Each digit is computed in 8-bit chunks by the shared divide unit, and the
// digits are stored least significant first in a small RAM. Then the minus
// sign is shown for a negative value, and each digit byte is read from the
// RAM and then shown, most significant first.
// A stalled beat holds its byte and flag until taken. Reset clears all
// configuration registers to zero (no valid base) and returns to idle.
module signed_integer_to_radix_digits_top
  import sitrd_pkg::*;
#(
  parameter int unsigned MAX_RADIX  = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            character_o,
  output logic                  last_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  localparam int unsigned AW   = $clog2(VALUE_BITS);
  localparam int unsigned CNTW = $clog2(VALUE_BITS + 1);

  st_e                   state_q, state_d;
  logic [CNTW-1:0]       cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic                  in_acc, out_acc, finish;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag;
  sym_table_t            symbols;
  logic [RADIX_BITS-1:0] radix;
  logic                  base_ok;
  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DIGIT_BITS-1:0] ram_rdata;

  sitrd_regs #(
    .MAX_RADIX(MAX_RADIX)
  ) u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .symbols_o(symbols),
    .radix_o  (radix),
    .base_ok_o(base_ok)
  );

  // Sign and magnitude of the incoming value
  assign neg_in = value_i[VALUE_BITS-1];
  assign mag    = neg_in ? (~value_i + VALUE_BITS'(1)) : value_i;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign finish  = div_stat.quot_zero || (cnt_q == CNTW'(VALUE_BITS - 1));

  sitrd_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .div_ctrl_i(div_ctrl),
    .dividend_i(mag),
    .radix_i   (radix),
    .div_stat_o(div_stat)
  );

  sitrd_ram #(
    .WIDTH(DIGIT_BITS),
    .DEPTH(VALUE_BITS)
  ) u_digits (
    .clk_i  (clk_i),
    .we_i   (div_stat.done),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(div_stat.digit),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && base_ok) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done && finish) begin
          state_d = neg_q ? ST_SIGN : ST_READ;
        end
      end
      ST_SIGN: begin
        if (out_acc) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_SHOW;
      ST_SHOW: begin
        if (out_acc) begin
          state_d = (cnt_q == '0) ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall_o   = 1'b1;
    out_valid_o  = 1'b0;
    character_o  = symbols[ram_rdata];
    last_o       = 1'b0;
    div_ctrl     = '0;
    ram_re       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        div_ctrl.start = in_valid_i && base_ok;
      end
      ST_DIV:  div_ctrl.run = 1'b1;
      ST_SIGN: begin
        out_valid_o = 1'b1;
        character_o = SYM_MINUS;
      end
      ST_READ: ram_re = 1'b1;
      ST_SHOW: begin
        out_valid_o = 1'b1;
        last_o      = (cnt_q == '0);
      end
      default: ;
    endcase
  end

  assign ram_raddr = cnt_d[AW-1:0];

  // Digit count and sign
  always_comb begin
    cnt_d = cnt_q;
    neg_d = neg_q;
    if (div_ctrl.start) begin
      cnt_d = '0;
      neg_d = neg_in;
    end else if (div_stat.done) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (ram_re) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      neg_q   <= neg_d;
    end
  end

  done_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIV)
    else $error("divide unit finished a digit outside the divide phase");

  count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNTW'(VALUE_BITS))
    else $error("digit count exceeds store depth");

  ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_o |=> !in_stall_o)
    else $error("not ready after the last beat of a value");

  read_has_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> cnt_q != '0)
    else $error("digit read with empty store");

endmodule

/* rtl/sitrd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sitrd_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sitrd_regs.sv */
// Configuration registers, APB access and alphabet validity check.
module sitrd_regs
  import sitrd_pkg::*;
#(
  parameter int unsigned MAX_RADIX = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready,
  output sym_table_t            symbols_o,
  output logic [RADIX_BITS-1:0] radix_o,
  output logic                  base_ok_o
);

  logic [63:0]           sym_low_q;
  logic [63:0]           sym_high_q;
  logic [RADIX_BITS-1:0] radix_q;
  logic                  wr_en;
  logic [1:0]            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_low_q  <= '0;
      sym_high_q <= '0;
      radix_q    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SYMBOLS_LOW:  sym_low_q  <= pwdata;
        REG_SYMBOLS_HIGH: sym_high_q <= pwdata;
        REG_RADIX_COUNT:  radix_q    <= pwdata[RADIX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_SYMBOLS_LOW:  prdata = sym_low_q;
      REG_SYMBOLS_HIGH: prdata = sym_high_q;
      REG_RADIX_COUNT:  prdata = 64'(radix_q);
      default:          prdata = '0;
    endcase
  end

  assign symbols_o = {sym_high_q, sym_low_q};
  assign radix_o   = radix_q;

  // Check the alphabet: radix in range, no sign symbols, no repeats
  always_comb begin
    base_ok_o = (radix_q >= RADIX_BITS'(2)) && (radix_q <= RADIX_BITS'(MAX_RADIX));
    for (int i = 0; i < SYM_COUNT; i++) begin
      if (RADIX_BITS'(i) < radix_q) begin
        if (symbols_o[i] == SYM_PLUS || symbols_o[i] == SYM_MINUS) begin
          base_ok_o = 1'b0;
        end
        for (int j = i + 1; j < SYM_COUNT; j++) begin
          if (RADIX_BITS'(j) < radix_q && symbols_o[i] == symbols_o[j]) begin
            base_ok_o = 1'b0;
          end
        end
      end
    end
  end

endmodule

/* rtl/sitrd_div.sv */
// Shared divide-by-radix unit: one 8-bit chunk of restoring division per cycle.
module sitrd_div
  import sitrd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  div_ctrl_t             div_ctrl_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  input  logic [RADIX_BITS-1:0] radix_i,
  output div_stat_t             div_stat_o
);

  localparam int unsigned CHUNKS = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int unsigned PAD    = CHUNKS * DIV_STEP_BITS;
  localparam int unsigned CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  logic [PAD-1:0]           work_q, work_d;
  logic [DIGIT_BITS-1:0]    rem_q, rem_d;
  logic [CW-1:0]            chunk_q;
  logic                     last_chunk;
  logic [DIV_STEP_BITS-1:0] qbits;
  logic [RADIX_BITS-1:0]    part;

  assign last_chunk = (chunk_q == CW'(CHUNKS - 1));

  // Restoring division over one chunk of dividend bits, most significant first
  always_comb begin
    part  = {1'b0, rem_q};
    qbits = '0;
    for (int s = 0; s < DIV_STEP_BITS; s++) begin
      part = {part[DIGIT_BITS-1:0], work_q[PAD-1-s]};
      if (part >= radix_i) begin
        part                       = part - radix_i;
        qbits[DIV_STEP_BITS-1-s]   = 1'b1;
      end
    end
    rem_d  = part[DIGIT_BITS-1:0];
    work_d = (work_q << DIV_STEP_BITS) | PAD'(qbits);
  end

  assign div_stat_o.done      = div_ctrl_i.run && last_chunk;
  assign div_stat_o.quot_zero = (work_d == '0);
  assign div_stat_o.digit     = rem_d;

  // Chunk counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= '0;
    end else if (div_ctrl_i.start) begin
      chunk_q <= '0;
    end else if (div_ctrl_i.run) begin
      chunk_q <= last_chunk ? '0 : chunk_q + CW'(1);
    end
  end

  // Dividend/quotient shifter and partial remainder
  always_ff @(posedge clk_i) begin
    if (div_ctrl_i.start) begin
      work_q <= PAD'(dividend_i);
      rem_q  <= '0;
    end else if (div_ctrl_i.run) begin
      work_q <= work_d;
      rem_q  <= last_chunk ? '0 : rem_d;
    end
  end

  chunk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_q <= CW'(CHUNKS - 1))
    else $error("divide chunk counter out of range");

  chunk_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat_o.done && !div_ctrl_i.start |=> chunk_q == '0)
    else $error("chunk counter did not wrap after a digit");

endmodule
